@@ sv/pinned_page_cache_directory_top_assert.svh @@
// Assertion macros used by the page cache directory sequencer.
`ifndef PINNED_PAGE_CACHE_DIRECTORY_TOP_ASSERT_SVH
`define PINNED_PAGE_CACHE_DIRECTORY_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PPCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ppcd_pkg.sv @@
// Types, constants and helper functions of the page cache directory.
package ppcd_pkg;

  localparam int ENTRIES    = 64;
  localparam int EIDX_W     = 6;
  localparam int SEG_W      = 16;
  localparam int PAGE_W     = 10;
  localparam int PB_W       = 13;
  localparam int PIN_W      = 16;
  localparam int BYTES_W    = 14;
  localparam int ALIGN_W    = 15;
  localparam int TLEN_W     = 14;
  localparam int REL_W      = 7;
  localparam int OFF_W      = 23;
  localparam int RD_W       = 10;

  localparam logic [BYTES_W-1:0] PAGE_BYTES = 14'd8192;
  localparam logic [RD_W-1:0]    RD_RESET   = 10'd32;
  localparam logic [PIN_W-1:0]   PIN_MAX    = 16'hFFFF;

  localparam logic [1:0] ACT_READ_PIN  = 2'd0;
  localparam logic [1:0] ACT_READ_ONCE = 2'd1;
  localparam logic [1:0] ACT_APPEND    = 2'd2;
  localparam logic [1:0] ACT_UNPIN     = 2'd3;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_WB    = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_IDX  = 3'd1;
  localparam logic [2:0] ERR_PIN_ZERO = 3'd2;
  localparam logic [2:0] ERR_NO_FREE  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [PAGE_W-1:0]  page;
    logic [PIN_W-1:0]   pin;
    logic               dirty;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [EIDX_W-1:0] entry;
    logic [SEG_W-1:0]  seg;
    logic [PAGE_W-1:0] page;
    logic [PB_W-1:0]   pbyte;
    logic [2:0]        err;
    logic              last;
  } result_t;

  function automatic logic [ALIGN_W-1:0] round_pow2(input logic [TLEN_W-1:0] tlen);
    logic [ALIGN_W-1:0] m;
    m = {1'b0, tlen} - 15'd1;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    if (tlen == '0) begin
      return 15'd1;
    end
    return m + 15'd1;
  endfunction

  function automatic logic [PIN_W-1:0] pin_up(input logic [PIN_W-1:0] p);
    return (p == PIN_MAX) ? p : p + 16'd1;
  endfunction

  function automatic logic [PIN_W-1:0] pin_down(input logic [PIN_W-1:0] p);
    return (p == '0) ? p : p - 16'd1;
  endfunction

endpackage

@@ sv/ppcd_store.sv @@
// Entry memory of the directory with per-entry valid bits and registered read.
module ppcd_store (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ppcd_pkg::EIDX_W-1:0] raddr,
  output ppcd_pkg::entry_t       rdata,
  input  logic                   we,
  input  logic [ppcd_pkg::EIDX_W-1:0] waddr,
  input  ppcd_pkg::entry_t       wdata
);
  import ppcd_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

@@ sv/ppcd_seq.sv @@
// Sequencer that walks the entry memory for lookups, replacement and pin updates.
`include "pinned_page_cache_directory_top_assert.svh"
module ppcd_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 action,
  input  logic [ppcd_pkg::SEG_W-1:0] segment,
  input  logic [ppcd_pkg::SEG_W-1:0] next_segment,
  input  logic [ppcd_pkg::OFF_W-1:0] byte_offset,
  input  logic [ppcd_pkg::TLEN_W-1:0] tuple_bytes,
  input  logic [ppcd_pkg::REL_W-1:0] entry_to_release,
  input  logic [ppcd_pkg::RD_W-1:0]  reserve_distance,
  input  logic                       out_free,
  output logic                       push,
  output ppcd_pkg::result_t          push_data
);
  import ppcd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_URD, S_UEV, S_LSTART, S_MRD, S_MEV, S_VRD, S_VEV,
    S_LWB, S_LFILL, S_POST, S_RES, S_EMIT, S_FIN
  } state_t;

  state_t              state, ret;
  logic [1:0]          act;
  logic [SEG_W-1:0]    seg, nseg, lk_seg;
  logic [PAGE_W-1:0]   page, lk_page;
  logic [PB_W-1:0]     pbyte;
  logic [ALIGN_W-1:0]  aligned;
  logic                lk_app, lk_res;
  logic [EIDX_W-1:0]   idx, cnt, cur_idx, vp;
  entry_t              cur, rdata, wdata, cur_mod;
  logic                wb_need;
  logic [SEG_W-1:0]    wb_seg;
  logic [PAGE_W-1:0]   wb_page;
  result_t             res, pend;
  logic                pend_v;
  logic                we;
  logic [EIDX_W-1:0]   waddr;
  logic [BYTES_W-1:0]  space;
  logic                ovf, full;
  logic [ALIGN_W-1:0]  sum;
  logic [PAGE_W:0]     rsum;

  ppcd_store u_store (
    .clk   (clk),
    .rst   (rst),
    .raddr (idx),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    space = PAGE_BYTES - ((cur.bytes > PAGE_BYTES) ? PAGE_BYTES : cur.bytes);
    ovf   = aligned > {1'b0, space};
    sum   = {1'b0, cur.bytes} + aligned;
    full  = (sum == {1'b0, PAGE_BYTES});
    rsum  = {1'b0, page} + {1'b0, reserve_distance};
    cur_mod = cur;
    if (lk_res) begin
      cur_mod.pin = pin_down(cur.pin);
    end else if (act != ACT_APPEND) begin
      if (act == ACT_READ_ONCE) begin
        cur_mod.pin = pin_down(cur.pin);
      end
    end else if (ovf) begin
      cur_mod.pin = pin_down(cur.pin);
    end else begin
      cur_mod.bytes = sum[BYTES_W-1:0];
      if (full) begin
        cur_mod.dirty = 1'b1;
        cur_mod.pin   = pin_down(pin_down(cur.pin));
      end else begin
        cur_mod.pin = pin_down(cur.pin);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = cur_mod;
    if (state == S_POST) begin
      we = 1'b1;
    end else if (state == S_UEV && rdata.pin != '0) begin
      we        = 1'b1;
      waddr     = idx;
      wdata     = rdata;
      wdata.pin = rdata.pin - 16'd1;
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = pend;
    if (state == S_EMIT && pend_v && out_free) begin
      push           = 1'b1;
      push_data.last = 1'b0;
    end else if (state == S_FIN && out_free) begin
      push           = 1'b1;
      push_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      pend_v <= 1'b0;
      vp     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act     <= action;
            seg     <= segment;
            nseg    <= next_segment;
            page    <= byte_offset[OFF_W-1:PB_W];
            pbyte   <= byte_offset[PB_W-1:0];
            aligned <= round_pow2(tuple_bytes);
            lk_seg  <= segment;
            lk_page <= byte_offset[OFF_W-1:PB_W];
            lk_app  <= (action == ACT_APPEND);
            lk_res  <= 1'b0;
            if (action == ACT_UNPIN) begin
              if (entry_to_release[REL_W-1]) begin
                res   <= '{KIND_ERROR, '0, '0, '0, '0, ERR_BAD_IDX, 1'b0};
                ret   <= S_FIN;
                state <= S_EMIT;
              end else begin
                idx   <= entry_to_release[EIDX_W-1:0];
                state <= S_URD;
              end
            end else begin
              state <= S_LSTART;
            end
          end
        end
        S_URD: state <= S_UEV;
        S_UEV: begin
          if (rdata.pin == '0) begin
            res <= '{KIND_ERROR, idx, '0, '0, '0, ERR_PIN_ZERO, 1'b0};
          end else begin
            res <= '{KIND_DONE, idx, '0, '0, '0, ERR_NONE, 1'b0};
          end
          ret   <= S_FIN;
          state <= S_EMIT;
        end
        S_LSTART: begin
          if (lk_seg == '0) begin
            res   <= '{KIND_ERROR, '0, '0, '0, '0, ERR_BAD_IDX, 1'b0};
            ret   <= S_FIN;
            state <= S_EMIT;
          end else begin
            idx   <= '0;
            state <= S_MRD;
          end
        end
        S_MRD: state <= S_MEV;
        S_MEV: begin
          if (rdata.seg == lk_seg && rdata.page == lk_page) begin
            cur     <= '{seg: rdata.seg, page: rdata.page, pin: pin_up(rdata.pin),
                         dirty: rdata.dirty, bytes: rdata.bytes};
            cur_idx <= idx;
            state   <= S_POST;
          end else if (idx == '1) begin
            idx   <= vp;
            cnt   <= '0;
            state <= S_VRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MRD;
          end
        end
        S_VRD: state <= S_VEV;
        S_VEV: begin
          if (rdata.pin == '0) begin
            vp        <= idx + 1'b1;
            cur_idx   <= idx;
            wb_need   <= (rdata.seg != '0) && rdata.dirty;
            wb_seg    <= rdata.seg;
            wb_page   <= rdata.page;
            cur.seg   <= lk_seg;
            cur.page  <= lk_page;
            cur.dirty <= 1'b0;
            cur.pin   <= lk_app ? 16'd2 : 16'd1;
            cur.bytes <= lk_app ? '0 : PAGE_BYTES;
            state     <= S_LWB;
          end else if (cnt == '1) begin
            res   <= '{KIND_ERROR, '0, '0, '0, '0, ERR_NO_FREE, 1'b0};
            ret   <= S_FIN;
            state <= S_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            cnt   <= cnt + 1'b1;
            state <= S_VRD;
          end
        end
        S_LWB: begin
          if (wb_need) begin
            res   <= '{KIND_WB, cur_idx, wb_seg, wb_page, '0, ERR_NONE, 1'b0};
            ret   <= S_LFILL;
            state <= S_EMIT;
          end else begin
            state <= S_LFILL;
          end
        end
        S_LFILL: begin
          if (!lk_app) begin
            res   <= '{KIND_FILL, cur_idx, lk_seg, lk_page, '0, ERR_NONE, 1'b0};
            ret   <= S_POST;
            state <= S_EMIT;
          end else begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (lk_res) begin
            state <= S_FIN;
          end else if (act == ACT_APPEND && ovf) begin
            res   <= '{KIND_ERROR, cur_idx, '0, '0, '0, ERR_OVERFLOW, 1'b0};
            ret   <= S_FIN;
            state <= S_EMIT;
          end else begin
            res   <= '{KIND_DONE, cur_idx, '0, '0, pbyte, ERR_NONE, 1'b0};
            ret   <= (act == ACT_APPEND && full) ? S_RES : S_FIN;
            state <= S_EMIT;
          end
        end
        S_RES: begin
          lk_seg  <= rsum[PAGE_W] ? nseg : seg;
          lk_page <= rsum[PAGE_W-1:0];
          lk_res  <= 1'b1;
          state   <= S_LSTART;
        end
        S_EMIT: begin
          if (!pend_v) begin
            pend   <= res;
            pend_v <= 1'b1;
            state  <= ret;
          end else if (out_free) begin
            pend  <= res;
            state <= ret;
          end
        end
        S_FIN: begin
          if (out_free) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPCD_ASSERT_SAME(a_idle_no_pend, in_ready, !pend_v, "held result left over at idle")
  `PPCD_ASSERT_SAME(a_push_free, push, out_free, "result pushed into a full output stage")
  `PPCD_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready high after transfer")
  `PPCD_ASSERT_SAME(a_fin_pend, state == S_FIN, pend_v, "finishing with no result held")

endmodule

@@ sv/pinned_page_cache_directory_top.sv @@
// Pinned page cache directory: stream ports, reserve-distance register, output stage.
// A lookup walks the entry memory one entry at a time, reading then comparing each;
// a miss scans all 64 entries, then seeks a free entry from the victim pointer.
// An append that fills a page runs a second lookup for the reservation.
// One item at a time; a new transfer waits until the last result is pushed to output.
// Sync reset clears valid bits and victim pointer, sets reserve distance 32; no sweep.
module pinned_page_cache_directory_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // segment, next_segment, byte_offset, tuple_bytes, entry_to_release, zero pad
  input  logic [79:0] s_tdata,
  // action
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry, out_segment, out_page, page_byte, error_code
  output logic [47:0] m_tdata,
  // kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);
  import ppcd_pkg::*;

  logic [RD_W-1:0] reserve_distance;
  logic            out_free, push;
  result_t         push_data, ores;

  assign out_free = !m_tvalid || m_tready;

  ppcd_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .action           (s_tuser),
    .segment          (s_tdata[15:0]),
    .next_segment     (s_tdata[31:16]),
    .byte_offset      (s_tdata[54:32]),
    .tuple_bytes      (s_tdata[68:55]),
    .entry_to_release (s_tdata[75:69]),
    .reserve_distance (reserve_distance),
    .out_free         (out_free),
    .push             (push),
    .push_data        (push_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_distance <= RD_RESET;
    end else if (cfg_we) begin
      reserve_distance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ores <= push_data;
    end
  end

  assign m_tdata = {ores.err, ores.pbyte, ores.page, ores.seg, ores.entry};
  assign m_tuser = ores.kind;
  assign m_tlast = ores.last;

endmodule

@@ tb/sv/tb_pinned_page_cache_directory_top.sv @@
// Self-checking testbench of the pinned page cache directory: queued requests, scoreboard.
module tb_pinned_page_cache_directory_top;
  import ppcd_pkg::*;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] seg;
    logic [15:0] nseg;
    logic [22:0] off;
    logic [13:0] tlen;
    logic [6:0]  rel;
  } request_t;

  localparam int SEG_BYTES = 1024 * 8192;
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [9:0]  cfg_wdata;

  request_t pending_reqs[$];
  result_t  expected_results[$];

  logic [15:0] dir_seg[ENTRIES];
  logic [9:0]  dir_page[ENTRIES];
  logic [15:0] dir_pin[ENTRIES];
  bit          dir_dirty[ENTRIES];
  int          dir_bytes[ENTRIES];
  int          victim_ptr;
  int          reserve_pages;

  int  mismatches;
  int  reqs_sent;
  int  results_seen;
  int  idle_cycles;
  int  in_gap;
  int  out_gap;
  bit  in_taken;
  bit  no_idling;
  request_t cur_req;

  pinned_page_cache_directory_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void push_result(logic [1:0] kind, int ent, logic [15:0] seg,
                                      logic [9:0] page, logic [12:0] pbyte, logic [2:0] err);
    expected_results.push_back(result_t'{kind, ent[5:0], seg, page, pbyte, err, 1'b0});
  endfunction

  function automatic void release_pin(int e);
    if (dir_pin[e] != 0) begin
      dir_pin[e]--;
    end
  endfunction

  function automatic int claim_page(logic [15:0] seg, logic [9:0] page, bit for_append);
    int c;
    bit found;
    if (seg == 0) begin
      push_result(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_IDX);
      return -1;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_seg[i] == seg && dir_page[i] == page) begin
        if (dir_pin[i] != PIN_MAX) begin
          dir_pin[i]++;
        end
        return i;
      end
    end
    found = 0;
    c = 0;
    for (int i = 0; i < ENTRIES && !found; i++) begin
      c = (victim_ptr + i) % ENTRIES;
      if (dir_pin[c] == 0) begin
        found = 1;
      end
    end
    if (!found) begin
      push_result(KIND_ERROR, 0, 0, 0, 0, ERR_NO_FREE);
      return -1;
    end
    victim_ptr = (c + 1) % ENTRIES;
    if (dir_seg[c] != 0 && dir_dirty[c]) begin
      push_result(KIND_WB, c, dir_seg[c], dir_page[c], 0, ERR_NONE);
    end
    dir_dirty[c] = 0;
    dir_seg[c] = seg;
    dir_page[c] = page;
    if (!for_append) begin
      push_result(KIND_FILL, c, seg, page, 0, ERR_NONE);
      dir_bytes[c] = 8192;
      dir_pin[c] = 1;
    end else begin
      dir_bytes[c] = 0;
      dir_pin[c] = 2;
    end
    return c;
  endfunction

  function automatic void predict_directory(request_t r);
    int first;
    int off;
    int roff;
    int e;
    int aligned;
    logic [15:0] rseg;
    logic [12:0] pbyte;
    logic [9:0] page;
    first = expected_results.size();
    off = int'(r.off) % SEG_BYTES;
    page = 10'(off / 8192);
    pbyte = 13'(off % 8192);
    if (r.act == ACT_UNPIN) begin
      if (r.rel >= ENTRIES) begin
        push_result(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_IDX);
      end else if (dir_pin[r.rel] == 0) begin
        push_result(KIND_ERROR, r.rel, 0, 0, 0, ERR_PIN_ZERO);
      end else begin
        dir_pin[r.rel]--;
        push_result(KIND_DONE, r.rel, 0, 0, 0, ERR_NONE);
      end
    end else if (r.act != ACT_APPEND) begin
      e = claim_page(r.seg, page, 0);
      if (e >= 0) begin
        if (r.act == ACT_READ_ONCE) begin
          release_pin(e);
        end
        push_result(KIND_DONE, e, 0, 0, pbyte, ERR_NONE);
      end
    end else begin
      aligned = 1;
      while (aligned < r.tlen) begin
        aligned = aligned << 1;
      end
      e = claim_page(r.seg, page, 1);
      if (e >= 0) begin
        if (aligned > 8192 - (dir_bytes[e] > 8192 ? 8192 : dir_bytes[e])) begin
          release_pin(e);
          push_result(KIND_ERROR, e, 0, 0, 0, ERR_OVERFLOW);
        end else begin
          dir_bytes[e] += aligned;
          if (dir_bytes[e] == 8192) begin
            dir_dirty[e] = 1;
            release_pin(e);
          end
          release_pin(e);
          push_result(KIND_DONE, e, 0, 0, pbyte, ERR_NONE);
          if (dir_bytes[e] == 8192) begin
            roff = off + reserve_pages * 8192;
            rseg = r.seg;
            if (roff >= SEG_BYTES) begin
              roff = roff % SEG_BYTES;
              rseg = r.nseg;
            end
            e = claim_page(rseg, 10'(roff / 8192), 1);
            if (e >= 0) begin
              release_pin(e);
            end
          end
        end
      end
    end
    if (expected_results.size() > first) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic bit pipeline_empty();
    return pending_reqs.size() == 0 && !s_tvalid && expected_results.size() == 0;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_directory(cur_req);
        reqs_sent++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = result_t'{m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[31:22],
                        m_tdata[44:32], m_tdata[47:45], m_tlast};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind %0d entry %0d", got.kind, got.entry);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp kind %0d ent %0d seg %h page %0d pb %0d err %0d last %0d",
                       want.kind, want.entry, want.seg, want.page, want.pbyte, want.err,
                       want.last);
              $display("          got kind %0d ent %0d seg %h page %0d pb %0d err %0d last %0d",
                       got.kind, got.entry, got.seg, got.page, got.pbyte, got.err, got.last);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || pipeline_empty()) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken || !s_tvalid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_tvalid <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 12) - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_tdata <= {4'd0, cur_req.rel, cur_req.tlen, cur_req.off, cur_req.nseg, cur_req.seg};
          s_tuser <= cur_req.act;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_tready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 12) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic [1:0] act, logic [15:0] seg, logic [15:0] nseg,
                           logic [22:0] off, logic [13:0] tlen, logic [6:0] rel);
    pending_reqs.push_back(request_t'{act, seg, nseg, off, tlen, rel});
  endtask

  task automatic drain_and_settle();
    while (!pipeline_empty()) begin
      @(posedge clk);
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reserve(logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    reserve_pages = int'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count);
    logic [15:0] seg;
    logic [22:0] off;
    logic [13:0] tlen;
    for (int i = 0; i < count; i++) begin
      seg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      off = ($urandom_range(0, 3) == 0) ? 23'($urandom) :
            23'({$urandom_range(0, 7), 13'($urandom)});
      case ($urandom_range(0, 3))
        0: tlen = 14'($urandom);
        1: tlen = 14'd8192;
        default: tlen = 14'(1 << $urandom_range(9, 12));
      endcase
      queue_req(2'($urandom), seg, 16'($urandom), off, tlen,
                ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    reqs_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    in_taken = 0;
    no_idling = 0;
    victim_ptr = 0;
    reserve_pages = 32;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_seg[i] = 0;
      dir_page[i] = 0;
      dir_pin[i] = 0;
      dir_dirty[i] = 0;
      dir_bytes[i] = 0;
    end
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_req(ACT_READ_PIN,  16'd1,     16'd2,     23'd0,       14'd1,     7'd0);
    queue_req(ACT_READ_ONCE, 16'd1,     16'd2,     23'd100,     14'd1,     7'd0);
    queue_req(ACT_READ_ONCE, 16'hFFFF,  16'hFFFF,  23'h7FFFFF,  14'h3FFF,  7'h7F);
    queue_req(ACT_READ_PIN,  16'd0,     16'd1,     23'd0,       14'd1,     7'd0);
    queue_req(ACT_APPEND,    16'd0,     16'd1,     23'd0,       14'd8,     7'd0);
    queue_req(ACT_APPEND,    16'd2,     16'd3,     23'd0,       14'd0,     7'd0);
    queue_req(ACT_APPEND,    16'd2,     16'd3,     23'd8192,    14'd8192,  7'd0);
    queue_req(ACT_APPEND,    16'd2,     16'd3,     23'd8195,    14'd3,     7'd0);
    queue_req(ACT_APPEND,    16'd2,     16'd3,     23'd40,      14'h3FFF,  7'd0);
    queue_req(ACT_APPEND,    16'd3,     16'hFFFF,  23'h7FE000,  14'd5000,  7'd0);
    queue_req(ACT_APPEND,    16'd3,     16'hFFFF,  23'h7FE010,  14'd4096,  7'd0);
    queue_req(ACT_APPEND,    16'd4,     16'd0,     23'h7FF000,  14'd8192,  7'd0);
    queue_req(ACT_APPEND,    16'd1,     16'd2,     23'd0,       14'd1,     7'd0);
    queue_req(ACT_UNPIN,     16'd0,     16'd0,     23'd0,       14'd0,     7'h7F);
    queue_req(ACT_UNPIN,     16'd0,     16'd0,     23'd0,       14'd0,     7'd64);
    queue_req(ACT_UNPIN,     16'd0,     16'd0,     23'd0,       14'd0,     7'd63);
    queue_req(ACT_UNPIN,     16'd0,     16'd0,     23'd0,       14'd0,     7'd0);
    queue_req(ACT_UNPIN,     16'd0,     16'd0,     23'd0,       14'd0,     7'd0);
    drain_and_settle();

    write_reserve(10'd1023);
    queue_random(12);
    drain_and_settle();
    write_reserve(10'($urandom_range(2, 1022)));
    queue_random(12);
    drain_and_settle();

    write_reserve(10'd1);
    no_idling = 1;
    for (int i = 0; i < 66; i++) begin
      queue_req(ACT_READ_PIN, 16'd100, 16'd1, 23'(i * 8192), 14'd1, 7'd0);
    end
    queue_req(ACT_APPEND, 16'd100, 16'd1, 23'h7FFFFF, 14'd1, 7'd0);
    for (int i = 0; i < 4; i++) begin
      queue_req(ACT_UNPIN, 16'd0, 16'd0, 23'd0, 14'd0, 7'(i));
    end
    drain_and_settle();

    $display("covered %0d requests and %0d results at reserve distances 1023, mid and 1,",
             reqs_sent, results_seen);
    $display("ending with every entry pinned and no free entry left");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ppcd_pkg.sv
sv/ppcd_store.sv
sv/ppcd_seq.sv
sv/pinned_page_cache_directory_top.sv
tb/sv/tb_pinned_page_cache_directory_top.sv
